[hw/rtl/izh_pkg.sv]
// Shared types, constants and saturation helper for the neuron update unit.
`timescale 1ns / 1ps

package izh_pkg;

	localparam int unsigned IDX_W = 10;

	// Q16.16 constant 0.04 and the Q16.16 form of 140.
	localparam logic signed [12:0] K_004   = 13'sd2621;
	localparam logic signed [63:0] K_140_Q = 64'sd9175040;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	localparam logic signed [31:0] THR_RESET = 32'sd1966080;

	// One neuron timestep as it travels down the pipeline.
	typedef struct packed {
		logic               vld;
		logic               in_range;
		logic [IDX_W-1:0]   idx;
		logic signed [31:0] v;
		logic signed [31:0] u;
		logic signed [31:0] cur;
		logic signed [31:0] pa;
		logic signed [31:0] pb;
		logic signed [31:0] pc;
		logic signed [31:0] pd;
	} tok_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > S32_MAX) begin
			r = 32'sh7fffffff;
		end else if (x < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

[hw/rtl/izh_state_mem.sv]
// Per-neuron state memory (voltage, recovery, history) with a clearing pass after reset.
`timescale 1ns / 1ps

module izh_state_mem #(
	parameter int NEURONS = 1024,
	parameter int HW      = 1,
	parameter int AW      = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic signed [31:0]   rd_v,
	output logic signed [31:0]   rd_u,
	output logic [HW*32-1:0]     rd_h,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic signed [31:0]   wr_v,
	input  logic signed [31:0]   wr_u,
	input  logic [HW*32-1:0]     wr_h,
	output logic                 clr_busy
);

	localparam int DW = 64 + HW * 32;

	logic [DW-1:0] mem [NEURONS];
	logic [DW-1:0] rd_q;
	logic [AW-1:0] clr_cnt_q;
	logic          clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == AW'(NEURONS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= {wr_h, wr_u, wr_v};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_v     = rd_q[31:0];
	assign rd_u     = rd_q[63:32];
	assign rd_h     = rd_q[DW-1:64];
	assign clr_busy = clr_busy_q;

endmodule

[hw/rtl/izh_euler_step.sv]
// One Euler sub-step of the voltage equation, five register stages deep.
`timescale 1ns / 1ps

module izh_euler_step #(
	parameter int STEPS = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic signed [31:0]       thr,
	input  izh_pkg::tok_t            tok_in,
	output izh_pkg::tok_t            tok_out,
	input  logic [izh_pkg::IDX_W-1:0] query_idx,
	output logic                     hit
);

	import izh_pkg::*;

	// Floor division by STEPS through a reciprocal multiply, exact for 32-bit magnitudes.
	localparam int          L     = $clog2(STEPS);
	localparam logic [63:0] RECIP = ((64'd1 << (32 + L)) + 64'(STEPS) - 64'd1) / 64'(STEPS);

	tok_t t_s1, t_s2, t_s3, t_s4, t_s5;
	logic act_s1, act_s2, act_s3, act_s4;
	logic signed [63:0] p1_s1;
	logic signed [34:0] v5_s1, v5_s2;
	logic signed [60:0] p2_s2;
	logic [31:0]        mag_s3;
	logic               neg_s3, neg_s4;
	logic [31:0]        q_s4;

	logic signed [47:0] sq1;
	logic signed [63:0] dsum;
	logic signed [31:0] delta;
	logic signed [32:0] dx;
	logic [32:0]        mag;
	logic [64:0]        prod;
	logic signed [32:0] step;
	logic signed [31:0] vnew;

	always_comb begin
		sq1   = 48'(p1_s1 >>> 16);
		dsum  = 64'(p2_s2 >>> 16) + 64'(v5_s2) + K_140_Q - 64'(t_s2.u) + 64'(t_s2.cur);
		delta = sat32(dsum);
		dx    = 33'(delta);
		mag   = delta[31] ? 33'(-dx + 33'(STEPS - 1)) : dx;
		prod  = 65'(mag_s3) * 65'(RECIP[32:0]);
		step  = neg_s4 ? -33'(q_s4) : 33'(q_s4);
		vnew  = sat32(64'(t_s4.v) + 64'(step));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_s1.vld <= 1'b0;
			t_s2.vld <= 1'b0;
			t_s3.vld <= 1'b0;
			t_s4.vld <= 1'b0;
			t_s5.vld <= 1'b0;
		end else if (en) begin
			t_s1   <= tok_in;
			act_s1 <= tok_in.v < thr;
			p1_s1  <= 64'($signed(tok_in.v)) * 64'($signed(tok_in.v));
			v5_s1  <= 35'($signed(tok_in.v)) * 35'sd5;

			t_s2   <= t_s1;
			act_s2 <= act_s1;
			p2_s2  <= 61'(sq1) * 61'(K_004);
			v5_s2  <= v5_s1;

			t_s3   <= t_s2;
			act_s3 <= act_s2;
			mag_s3 <= mag[31:0];
			neg_s3 <= delta[31];

			t_s4   <= t_s3;
			act_s4 <= act_s3;
			q_s4   <= 32'(prod >> (32 + L));
			neg_s4 <= neg_s3;

			t_s5   <= t_s4;
			if (act_s4) begin
				t_s5.v <= vnew;
			end
		end
	end

	assign tok_out = t_s5;
	assign hit = (t_s1.vld && t_s1.idx == query_idx) || (t_s2.vld && t_s2.idx == query_idx) ||
		(t_s3.vld && t_s3.idx == query_idx) || (t_s4.vld && t_s4.idx == query_idx) ||
		(t_s5.vld && t_s5.idx == query_idx);

endmodule

[hw/rtl/izh_recovery.sv]
// Recovery update, spike test and post-spike reset, five register stages deep.
`timescale 1ns / 1ps

module izh_recovery (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic signed [31:0]        thr,
	input  izh_pkg::tok_t             tok_in,
	output izh_pkg::tok_t             tok_out,
	output logic                      spike,
	input  logic [izh_pkg::IDX_W-1:0] query_idx,
	output logic                      hit
);

	import izh_pkg::*;

	tok_t t_r1, t_r2, t_r3, t_r4, t_r5;
	logic signed [63:0] p_r1, p_r3;
	logic signed [31:0] diff_r2, u_r4;
	logic               spk_r4, spk_r5;

	logic signed [31:0] bv, au, u1, ud;

	always_comb begin
		bv = sat32(p_r1 >>> 16);
		au = sat32(p_r3 >>> 16);
		u1 = sat32(64'(t_r3.u) + 64'(au));
		ud = sat32(64'(u_r4) + 64'(t_r4.pd));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_r1.vld <= 1'b0;
			t_r2.vld <= 1'b0;
			t_r3.vld <= 1'b0;
			t_r4.vld <= 1'b0;
			t_r5.vld <= 1'b0;
		end else if (en) begin
			t_r1    <= tok_in;
			p_r1    <= 64'($signed(tok_in.pb)) * 64'($signed(tok_in.v));

			t_r2    <= t_r1;
			diff_r2 <= sat32(64'(bv) - 64'(t_r1.u));

			t_r3    <= t_r2;
			p_r3    <= 64'($signed(t_r2.pa)) * 64'(diff_r2);

			t_r4    <= t_r3;
			u_r4    <= u1;
			spk_r4  <= t_r3.v >= thr;

			t_r5    <= t_r4;
			spk_r5  <= spk_r4;
			if (spk_r4) begin
				t_r5.v <= t_r4.pc;
				t_r5.u <= ud;
			end else begin
				t_r5.u <= u_r4;
			end
		end
	end

	assign tok_out = t_r5;
	assign spike   = spk_r5;
	assign hit = (t_r1.vld && t_r1.idx == query_idx) || (t_r2.vld && t_r2.idx == query_idx) ||
		(t_r3.vld && t_r3.idx == query_idx) || (t_r4.vld && t_r4.idx == query_idx) ||
		(t_r5.vld && t_r5.idx == query_idx);

endmodule

[hw/rtl/izhikevich_neuron_update_unit.sv]
// Top level of the Izhikevich neuron update unit: state memory, Euler chain, recovery, output.
`timescale 1ns / 1ps
//
// Channel    Dir  Content
// s_axis     in   one neuron timestep: index, input current, a, b, c, d
// m_axis     out  updated neuron: index, spike flag, voltage, recovery, history
// cfg        in   spike threshold write (Q16.16 signed)
//
// A beat can enter in every cycle unless one of the conditions that follow holds it. It passes
// one state memory read stage, five stages per Euler sub-step, five recovery stages and
// the output register. A beat whose neuron is still in flight waits at s_axis until that
// neuron is written back. After reset a clearing pass zeroes the state memory; no beat is
// taken during it. A stall at m_axis freezes the whole pipeline in place.

module izhikevich_neuron_update_unit #(
	parameter int NEURONS       = 1024,
	parameter int EULER_STEPS   = 2,
	parameter int HISTORY_WORDS = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// [9:0] neuron_index, [41:10] input_current, [73:42] param_a, [105:74] param_b,
	// [137:106] param_c, [169:138] param_d, [175:170] zero
	input  logic [175:0]  s_axis_tdata,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// [9:0] out_index, [10] spiked, [42:11] new_voltage, [74:43] new_recovery,
	// [106:75] history_word, [111:107] zero
	output logic [111:0]  m_axis_tdata,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata
);

	import izh_pkg::*;

	localparam int AW  = (NEURONS > 1) ? $clog2(NEURONS) : 1;
	localparam int HB  = HISTORY_WORDS * 32;
	localparam int LAT = 5 * EULER_STEPS + 5;

	logic signed [31:0] thr_q;

	// The pipeline moves whenever the output register is free or being emptied.
	logic en, hazard, clr_busy, accept;
	logic [IDX_W-1:0] qidx;

	tok_t req_s1;
	tok_t tok_e [EULER_STEPS+1];
	tok_t rec;
	logic [EULER_STEPS-1:0] hit_e;
	logic hit_r, spike;

	logic signed [31:0] rd_v, rd_u;
	logic [HB-1:0]      rd_h, hist0, wr_h;
	logic [HB-1:0]      hist_dly_q [LAT];
	logic               wr_en;

	logic               m_valid_q;
	logic [IDX_W-1:0]   idx_q;
	logic               spk_q;
	logic signed [31:0] v_q, u_q;
	logic [31:0]        h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign en     = !m_valid_q || m_axis_tready;
	assign qidx   = s_axis_tdata[IDX_W-1:0];
	assign hazard = (req_s1.vld && req_s1.idx == qidx) || (|hit_e) || hit_r;
	assign s_axis_tready = en && !clr_busy && !hazard;
	assign accept = s_axis_tvalid && s_axis_tready;

	// Request stage: payload is held here while the state memory read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1.vld <= 1'b0;
		end else if (en) begin
			req_s1.vld      <= accept;
			req_s1.idx      <= qidx;
			req_s1.in_range <= {7'b0, qidx} < 17'(NEURONS);
			req_s1.v        <= '0;
			req_s1.u        <= '0;
			req_s1.cur      <= s_axis_tdata[41:10];
			req_s1.pa       <= s_axis_tdata[73:42];
			req_s1.pb       <= s_axis_tdata[105:74];
			req_s1.pc       <= s_axis_tdata[137:106];
			req_s1.pd       <= s_axis_tdata[169:138];
		end
	end

	izh_state_mem #(
		.NEURONS (NEURONS),
		.HW      (HISTORY_WORDS),
		.AW      (AW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (AW'(qidx)),
		.rd_v     (rd_v),
		.rd_u     (rd_u),
		.rd_h     (rd_h),
		.wr_en    (wr_en),
		.wr_addr  (AW'(rec.idx)),
		.wr_v     (rec.v),
		.wr_u     (rec.u),
		.wr_h     (wr_h),
		.clr_busy (clr_busy)
	);

	// An index beyond the store starts from zero state and is never written back.
	always_comb begin
		tok_e[0] = req_s1;
		if (req_s1.in_range) begin
			tok_e[0].v = rd_v;
			tok_e[0].u = rd_u;
			hist0      = rd_h;
		end else begin
			hist0      = '0;
		end
	end

	for (genvar k = 0; k < EULER_STEPS; k++) begin : g_euler
		izh_euler_step #(
			.STEPS (EULER_STEPS)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.thr       (thr_q),
			.tok_in    (tok_e[k]),
			.tok_out   (tok_e[k+1]),
			.query_idx (qidx),
			.hit       (hit_e[k])
		);
	end

	izh_recovery u_rec (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.thr       (thr_q),
		.tok_in    (tok_e[EULER_STEPS]),
		.tok_out   (rec),
		.spike     (spike),
		.query_idx (qidx),
		.hit       (hit_r)
	);

	// The history row skips the arithmetic and is shifted just before write-back.
	always_ff @(posedge clk) begin
		if (en) begin
			hist_dly_q[0] <= hist0;
			for (int i = 1; i < LAT; i++) begin
				hist_dly_q[i] <= hist_dly_q[i-1];
			end
		end
	end

	assign wr_h  = {hist_dly_q[LAT-1][HB-2:0], spike};
	assign wr_en = en && rec.vld && rec.in_range;

	// Output register: holds the result for m_axis; the downstream ready still gates the whole pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= rec.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_q <= rec.idx;
			spk_q <= spike;
			v_q   <= rec.v;
			u_q   <= rec.u;
			h_q   <= wr_h[31:0];
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'b0, h_q, u_q, v_q, spk_q, idx_q};

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !clr_busy)
		else $error("beat accepted during the clearing pass");

	a_writeback_shows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> m_axis_tvalid)
		else $error("written-back neuron did not reach the output register");

	a_req_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (req_s1.vld && req_s1.idx == $past(qidx)))
		else $error("accepted beat missing from the request stage");

endmodule
